// ----- rtl/rta_pkg.sv -----
package rta_pkg;

  // Mode codes carried by the input word
  localparam logic ModeGroup = 1'b0;
  localparam logic ModeRead  = 1'b1;

  // RDS group types handled here
  localparam logic [3:0] GroupPs = 4'd0;
  localparam logic [3:0] GroupRt = 4'd2;

  // Accepted character range: name 32..126, text 32..127
  localparam logic [7:0] CharMin   = 8'd32;
  localparam logic [7:0] NameMax   = 8'd126;
  localparam logic [7:0] TextMax   = 8'd127;

  localparam int unsigned NameLen  = 8;
  localparam int unsigned TextRows = 16;  // 4 characters per row

  typedef struct packed {
    logic        mode;
    logic        rds_ready;
    logic [15:0] block_b;
    logic [15:0] block_c;
    logic [15:0] block_d;
    logic [3:0]  segment_select;
    logic        clear_flag;
  } in_word_t;

  typedef struct packed {
    logic [63:0] station_name;
    logic [31:0] text_segment;
    logic        text_updated;
  } out_word_t;

endpackage

// ----- rtl/rds_text_assembler.sv -----
// Channel | Direction | Handshake                  | Word
// --------+-----------+----------------------------+-----------------------
// in      | input     | in_valid_i / in_stall_o    | rta_pkg::in_word_t
// out     | output    | out_valid_o / out_stall_i  | rta_pkg::out_word_t
//
// One word per cycle sustained while the output does not stall; an accepted
// word passes the read stage (text memory read), then the output register.
// The text buffer is a 16 x 32 memory with a registered read; each row has a
// valid bit, so reset clears it at once and no clearing pass is needed.
// A stalled output holds; the input keeps being taken while the read stage
// is free or moving into the output register.
module rds_text_assembler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rta_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rta_pkg::out_word_t out_data_o
);

  // ---------------------------------------------------------------------------
  // Handshake and pipeline control
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_move;
  logic in_acc;

  assign s1_move    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign s1_valid_d  = in_acc ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_move ? s1_valid_q : out_valid_q;

  // ---------------------------------------------------------------------------
  // Group decode
  // ---------------------------------------------------------------------------
  logic [3:0] gtype;
  logic       grp;      // ready group accepted
  logic       ps_wr;    // station name group (0A / 0B)
  logic       rt_wr;    // radio text group (2A only)
  logic       clr;

  assign gtype = in_data_i.block_b[15:12];
  assign grp   = in_acc && (in_data_i.mode == rta_pkg::ModeGroup) && in_data_i.rds_ready;
  assign ps_wr = grp && (gtype == rta_pkg::GroupPs);
  assign rt_wr = grp && (gtype == rta_pkg::GroupRt) && !in_data_i.block_b[11];
  assign clr   = in_acc && (in_data_i.mode == rta_pkg::ModeRead) && in_data_i.clear_flag;

  // ---------------------------------------------------------------------------
  // Station name: eight characters, each read at its own place
  // ---------------------------------------------------------------------------
  logic [7:0] name_q [rta_pkg::NameLen];
  logic [7:0] name_d [rta_pkg::NameLen];
  logic [2:0] name_slot_hi, name_slot_lo;
  logic [7:0] name_ch_hi, name_ch_lo;
  logic [63:0] name_flat;

  assign name_slot_hi = {in_data_i.block_b[1:0], 1'b0};
  assign name_slot_lo = {in_data_i.block_b[1:0], 1'b1};
  assign name_ch_hi   = in_data_i.block_d[15:8];
  assign name_ch_lo   = in_data_i.block_d[7:0];

  always_comb begin
    name_d = name_q;
    if (ps_wr) begin
      if (name_ch_hi >= rta_pkg::CharMin && name_ch_hi <= rta_pkg::NameMax) begin
        name_d[name_slot_hi] = name_ch_hi;
      end
      if (name_ch_lo >= rta_pkg::CharMin && name_ch_lo <= rta_pkg::NameMax) begin
        name_d[name_slot_lo] = name_ch_lo;
      end
    end
  end

  // character 0 lands in the top byte
  always_comb begin
    name_flat = '0;
    for (int i = 0; i < rta_pkg::NameLen; i++) begin
      name_flat[63 - 8*i -: 8] = name_d[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Updated flag: set by a handled group, cleared by a read with clear_flag set that reports it
  // ---------------------------------------------------------------------------
  logic flag_q, flag_d, flag_rpt;

  assign flag_rpt = flag_q || ps_wr || rt_wr;   // value reported for this word
  assign flag_d   = clr ? 1'b0 : flag_rpt;

  // ---------------------------------------------------------------------------
  // Radio text memory: row = segment address, first character in bits 31:24
  // ---------------------------------------------------------------------------
  logic [31:0] text_mem [rta_pkg::TextRows];
  logic [rta_pkg::TextRows-1:0] row_vld_q, row_vld_d;
  logic [3:0]  wr_row, rd_row;
  logic [31:0] wr_raw, wr_data;
  logic [3:0]  wr_ok, wr_be;
  logic [31:0] rd_q;

  assign wr_row = in_data_i.block_b[3:0];
  assign rd_row = in_data_i.segment_select;
  assign wr_raw = {in_data_i.block_c, in_data_i.block_d};

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      wr_ok[3-b] = (wr_raw[31 - 8*b -: 8] >= rta_pkg::CharMin) &&
                   (wr_raw[31 - 8*b -: 8] <= rta_pkg::TextMax);
      wr_data[31 - 8*b -: 8] = wr_ok[3-b] ? wr_raw[31 - 8*b -: 8] : 8'h00;
    end
    // a row never written reads as zero, so its first write fills all bytes
    wr_be = row_vld_q[wr_row] ? wr_ok : 4'hF;
    row_vld_d = row_vld_q;
    if (rt_wr) begin
      row_vld_d[wr_row] = 1'b1;
    end
  end

  // read returns the row as it was before this edge's write
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q <= text_mem[rd_row];
    end
    if (rt_wr) begin
      for (int b = 0; b < 4; b++) begin
        if (wr_be[b]) begin
          text_mem[wr_row][8*b +: 8] <= wr_data[8*b +: 8];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Read stage: word side data held beside the memory read
  // ---------------------------------------------------------------------------
  logic [63:0] s1_name_q;
  logic        s1_flag_q;
  logic        s1_rowv_q;
  logic        s1_hit_q;    // this word wrote the row it reads
  logic [3:0]  s1_be_q;
  logic [31:0] s1_wdata_q;
  logic [31:0] text_fwd;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_name_q  <= name_flat;
      s1_flag_q  <= flag_rpt;
      s1_rowv_q  <= row_vld_q[rd_row];
      s1_hit_q   <= rt_wr && (wr_row == rd_row);
      s1_be_q    <= wr_be;
      s1_wdata_q <= wr_data;
    end
  end

  always_comb begin
    text_fwd = s1_rowv_q ? rd_q : 32'h0;
    for (int b = 0; b < 4; b++) begin
      if (s1_hit_q && s1_be_q[b]) begin
        text_fwd[8*b +: 8] = s1_wdata_q[8*b +: 8];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  rta_pkg::out_word_t out_q;

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_valid_q) begin
      out_q.station_name <= s1_name_q;
      out_q.text_segment <= text_fwd;
      out_q.text_updated <= s1_flag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flag_q      <= 1'b0;
      row_vld_q   <= '0;
      for (int i = 0; i < rta_pkg::NameLen; i++) begin
        name_q[i] <= 8'h00;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      flag_q      <= flag_d;
      row_vld_q   <= row_vld_d;
      name_q      <= name_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_clear_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |=> !flag_q)
    else $error("updated flag not cleared by read");

  a_set_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ps_wr || rt_wr) |=> flag_q)
    else $error("updated flag not set by handled group");

  a_row_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_wr |=> row_vld_q[$past(wr_row)])
    else $error("text row not marked valid after write");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |=> (s1_valid_q && $stable(rd_q) && $stable(s1_name_q)))
    else $error("read stage lost its word while blocked");

endmodule
